// ===== src/er3d_pkg.sv =====
// Shared types, constants and step tables for the Euler-angle 3D rotator.
`default_nettype none

package er3d_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int OUT_W       = SAMPLE_W + 1;
    localparam int ANGLE_W     = 16;
    localparam int COEF_FRAC   = 16;
    localparam int COEF_W      = COEF_FRAC + 2;
    localparam int PROD_W      = COEF_W + SAMPLE_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int SUM_W       = ACC_W - COEF_FRAC;
    localparam int IN_DATA_W   = ((3 * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((3 * OUT_W + 7) / 8) * 8;
    localparam int NUM_LANES   = 3;
    localparam int NUM_SINES   = 6;
    localparam int NUM_COEF    = 9;
    localparam int NUM_STEPS   = 14;
    localparam int COEF_ZX     = 6;
    localparam int OUT_MAX     = (1 << SAMPLE_W) - 1;
    localparam int OUT_MIN     = -(1 << SAMPLE_W);

    localparam logic [ANGLE_W-1:0] QUARTER = 16'h4000;
    localparam logic [30:0] POLY_A = 31'd1686629713;
    localparam logic [30:0] POLY_B = 31'd693598668;
    localparam logic [30:0] POLY_C = 31'd85569306;
    localparam logic [30:0] POLY_D = 31'd5026995;
    localparam logic [30:0] POLY_E = 31'd172272;

    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef coef_t coef_mat_t [NUM_COEF];

    typedef enum logic [1:0] {
        REG_ANGLE_X,
        REG_ANGLE_Y,
        REG_ANGLE_Z
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_POLY,
        ST_FINISH,
        ST_PRODUCT
    } seq_state_t;

    typedef enum logic [2:0] {
        SRC_SX,
        SRC_CX,
        SRC_SY,
        SRC_CY,
        SRC_SZ,
        SRC_CZ,
        SRC_CZSY,
        SRC_SZSY
    } src_t;

    typedef enum logic [3:0] {
        DST_XX,
        DST_XY,
        DST_XZ,
        DST_YX,
        DST_YY,
        DST_YZ,
        DST_ZX,
        DST_ZY,
        DST_ZZ,
        DST_CZSY,
        DST_SZSY
    } dst_t;

    typedef enum logic [1:0] {
        WB_SET,
        WB_NEG,
        WB_ADD
    } wb_t;

    typedef struct packed {
        src_t a;
        src_t b;
        dst_t dst;
        wb_t  mode;
    } prod_step_t;

    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } lane_ctl_t;

    function automatic logic [30:0] poly_const(input logic [1:0] k);
        logic [30:0] c;
        case (k)
            2'd0:    c = POLY_D;
            2'd1:    c = POLY_C;
            2'd2:    c = POLY_B;
            default: c = POLY_A;
        endcase
        return c;
    endfunction

    function automatic prod_step_t prod_step(input logic [3:0] idx);
        prod_step_t s;
        case (idx)
            4'd0:    s = '{a: SRC_CZ,   b: SRC_SY, dst: DST_CZSY, mode: WB_SET};
            4'd1:    s = '{a: SRC_SZ,   b: SRC_SY, dst: DST_SZSY, mode: WB_SET};
            4'd2:    s = '{a: SRC_CZ,   b: SRC_CY, dst: DST_XX,   mode: WB_SET};
            4'd3:    s = '{a: SRC_SZ,   b: SRC_CX, dst: DST_XY,   mode: WB_NEG};
            4'd4:    s = '{a: SRC_CZSY, b: SRC_SX, dst: DST_XY,   mode: WB_ADD};
            4'd5:    s = '{a: SRC_SZ,   b: SRC_SX, dst: DST_XZ,   mode: WB_SET};
            4'd6:    s = '{a: SRC_CZSY, b: SRC_CX, dst: DST_XZ,   mode: WB_ADD};
            4'd7:    s = '{a: SRC_SZ,   b: SRC_CY, dst: DST_YX,   mode: WB_SET};
            4'd8:    s = '{a: SRC_CZ,   b: SRC_CX, dst: DST_YY,   mode: WB_SET};
            4'd9:    s = '{a: SRC_SZSY, b: SRC_SX, dst: DST_YY,   mode: WB_ADD};
            4'd10:   s = '{a: SRC_CZ,   b: SRC_SX, dst: DST_YZ,   mode: WB_NEG};
            4'd11:   s = '{a: SRC_SZSY, b: SRC_CX, dst: DST_YZ,   mode: WB_ADD};
            4'd12:   s = '{a: SRC_CY,   b: SRC_SX, dst: DST_ZY,   mode: WB_SET};
            default: s = '{a: SRC_CY,   b: SRC_CX, dst: DST_ZZ,   mode: WB_SET};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/er3d_coef.sv =====
// Angle registers and the shared-multiplier sequencer that rebuilds the rotation matrix.
`default_nettype none

module er3d_coef (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [er3d_pkg::ANGLE_W-1:0]  cfg_wdata,
    output logic                               busy,
    output er3d_pkg::coef_mat_t                coef
);
    import er3d_pkg::*;

    logic [ANGLE_W-1:0] angle_x_reg, angle_x_next;
    logic [ANGLE_W-1:0] angle_y_reg, angle_y_next;
    logic [ANGLE_W-1:0] angle_z_reg, angle_z_next;
    seq_state_t         state_reg, state_next;
    logic               phase_reg, phase_next;
    logic [2:0]         sel_reg, sel_next;
    logic [1:0]         poly_reg, poly_next;
    logic [3:0]         step_reg, step_next;
    logic [30:0]        x2_reg, x2_next;
    logic [30:0]        p_reg, p_next;
    coef_t              sine_reg [NUM_SINES];
    coef_t              sine_next [NUM_SINES];
    coef_t              czsy_reg, czsy_next;
    coef_t              szsy_reg, szsy_next;
    coef_mat_t          coef_reg, coef_next;
    logic signed [63:0] mul_reg;

    logic [ANGLE_W-1:0] angle_sel;
    logic [ANGLE_W-1:0] angle_eff;
    logic [1:0]         quad;
    logic [14:0]        u_val;
    logic [ANGLE_W-1:0] u_wide;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    prod_step_t         pstep;
    coef_t              val_a;
    coef_t              val_b;
    logic [31:0]        s30;
    logic [32:0]        s_full;
    logic [COEF_FRAC:0] s_mag;
    coef_t              sine_val;
    logic signed [63:0] rnd_full;
    coef_t              rnd;
    coef_t              wb_val;
    logic [3:0]         dst_idx;

    always_comb begin
        case (sel_reg)
            3'd0, 3'd1: angle_sel = angle_x_reg;
            3'd2, 3'd3: angle_sel = angle_y_reg;
            default:    angle_sel = angle_z_reg;
        endcase
        angle_eff = angle_sel + (sel_reg[0] ? QUARTER : '0);
        quad      = angle_eff[ANGLE_W-1:ANGLE_W-2];
        u_wide    = QUARTER - {2'b00, angle_eff[ANGLE_W-3:0]};
        u_val     = quad[0] ? u_wide[14:0] : {1'b0, angle_eff[ANGLE_W-3:0]};
    end

    function automatic coef_t pick(input src_t s, input coef_t sx, input coef_t cx,
                                   input coef_t sy, input coef_t cy, input coef_t sz,
                                   input coef_t cz, input coef_t czsy, input coef_t szsy);
        coef_t v;
        case (s)
            SRC_SX:   v = sx;
            SRC_CX:   v = cx;
            SRC_SY:   v = sy;
            SRC_CY:   v = cy;
            SRC_SZ:   v = sz;
            SRC_CZ:   v = cz;
            SRC_CZSY: v = czsy;
            default:  v = szsy;
        endcase
        return v;
    endfunction

    always_comb begin
        pstep = prod_step(step_reg);
        val_a = pick(pstep.a, sine_reg[0], sine_reg[1], sine_reg[2], sine_reg[3],
                     sine_reg[4], sine_reg[5], czsy_reg, szsy_reg);
        val_b = pick(pstep.b, sine_reg[0], sine_reg[1], sine_reg[2], sine_reg[3],
                     sine_reg[4], sine_reg[5], czsy_reg, szsy_reg);
        case (state_reg)
            ST_SQUARE: begin
                op_a = {17'b0, u_val};
                op_b = {17'b0, u_val};
            end
            ST_POLY: begin
                op_a = {1'b0, x2_reg};
                op_b = {1'b0, p_reg};
            end
            ST_FINISH: begin
                op_a = {17'b0, u_val};
                op_b = {1'b0, p_reg};
            end
            ST_PRODUCT: begin
                op_a = 32'(val_a);
                op_b = 32'(val_b);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_reg <= op_a * op_b;
    end

    always_comb begin
        s30    = mul_reg[45:14];
        s_full = ({1'b0, s30} + 33'(1 << (29 - COEF_FRAC))) >> (30 - COEF_FRAC);
        s_mag  = (s_full > 33'(1 << COEF_FRAC)) ? (COEF_FRAC+1)'(1 << COEF_FRAC)
                                               : s_full[COEF_FRAC:0];
        sine_val = quad[1] ? -coef_t'({1'b0, s_mag}) : coef_t'({1'b0, s_mag});
        rnd_full = (mul_reg + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        rnd      = rnd_full[COEF_W-1:0];
        dst_idx  = pstep.dst;
    end

    always_comb begin
        angle_x_next = angle_x_reg;
        angle_y_next = angle_y_reg;
        angle_z_next = angle_z_reg;
        state_next   = state_reg;
        phase_next   = phase_reg;
        sel_next     = sel_reg;
        poly_next    = poly_reg;
        step_next    = step_reg;
        x2_next      = x2_reg;
        p_next       = p_reg;
        sine_next    = sine_reg;
        czsy_next    = czsy_reg;
        szsy_next    = szsy_reg;
        coef_next    = coef_reg;
        wb_val       = rnd;

        if (state_reg != ST_IDLE) begin
            phase_next = !phase_reg;
        end

        case (state_reg)
            ST_SQUARE: begin
                if (phase_reg) begin
                    x2_next    = {mul_reg[28:0], 2'b00};
                    p_next     = POLY_E;
                    poly_next  = '0;
                    state_next = ST_POLY;
                end
            end
            ST_POLY: begin
                if (phase_reg) begin
                    p_next    = poly_const(poly_reg) - mul_reg[60:30];
                    poly_next = poly_reg + 2'd1;
                    if (poly_reg == 2'd3) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (phase_reg) begin
                    sine_next[sel_reg] = sine_val;
                    if (sel_reg == 3'(NUM_SINES - 1)) begin
                        step_next  = '0;
                        state_next = ST_PRODUCT;
                    end else begin
                        sel_next   = sel_reg + 3'd1;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_PRODUCT: begin
                if (phase_reg) begin
                    case (pstep.mode)
                        WB_SET:  wb_val = rnd;
                        WB_NEG:  wb_val = -rnd;
                        WB_ADD:  wb_val = coef_reg[dst_idx] + rnd;
                        default: wb_val = rnd;
                    endcase
                    case (pstep.dst)
                        DST_CZSY: czsy_next = wb_val;
                        DST_SZSY: szsy_next = wb_val;
                        default:  coef_next[dst_idx] = wb_val;
                    endcase
                    step_next = step_reg + 4'd1;
                    if (step_reg == 4'(NUM_STEPS - 1)) begin
                        coef_next[COEF_ZX] = -sine_reg[2];
                        state_next         = ST_IDLE;
                    end
                end
            end
            default: ;
        endcase

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ANGLE_X: angle_x_next = cfg_wdata;
                REG_ANGLE_Y: angle_y_next = cfg_wdata;
                REG_ANGLE_Z: angle_z_next = cfg_wdata;
                default: ;
            endcase
            if (cfg_addr inside {REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z}) begin
                state_next = ST_SQUARE;
                sel_next   = '0;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            sel_reg     <= '0;
            poly_reg    <= '0;
            step_reg    <= '0;
            for (int i = 0; i < NUM_COEF; i++) begin
                coef_reg[i] <= (i == 0 || i == 4 || i == 8) ? coef_t'(1 << COEF_FRAC) : '0;
            end
        end else begin
            angle_x_reg <= angle_x_next;
            angle_y_reg <= angle_y_next;
            angle_z_reg <= angle_z_next;
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            sel_reg     <= sel_next;
            poly_reg    <= poly_next;
            step_reg    <= step_next;
            coef_reg    <= coef_next;
        end
    end

    always_ff @(posedge aclk) begin
        x2_reg   <= x2_next;
        p_reg    <= p_next;
        sine_reg <= sine_next;
        czsy_reg <= czsy_next;
        szsy_reg <= szsy_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign coef = coef_reg;

endmodule

`default_nettype wire

// ===== src/er3d_lane.sv =====
// One matrix row: three products and a rounded sum over two register stages.
`default_nettype none

module er3d_lane (
    input  wire logic                  aclk,
    input  wire er3d_pkg::lane_ctl_t   ctl,
    input  wire er3d_pkg::coef_t       coef_a,
    input  wire er3d_pkg::coef_t       coef_b,
    input  wire er3d_pkg::coef_t       coef_c,
    input  wire er3d_pkg::sample_t     x_in,
    input  wire er3d_pkg::sample_t     y_in,
    input  wire er3d_pkg::sample_t     z_in,
    output er3d_pkg::sum_t             sum
);
    import er3d_pkg::*;

    logic signed [PROD_W-1:0] prod_a_reg;
    logic signed [PROD_W-1:0] prod_b_reg;
    logic signed [PROD_W-1:0] prod_c_reg;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_rnd;
    sum_t                     sum_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            prod_a_reg <= coef_a * x_in;
            prod_b_reg <= coef_b * y_in;
            prod_c_reg <= coef_c * z_in;
        end
    end

    always_comb begin
        acc     = ACC_W'(prod_a_reg) + ACC_W'(prod_b_reg) + ACC_W'(prod_c_reg);
        acc_rnd = (acc + ACC_W'(1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_sum) begin
            sum_reg <= acc_rnd[SUM_W-1:0];
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// ===== src/er3d_merge.sv =====
// Output stage: clamp the three lane sums and pack them into one result beat.
`default_nettype none

module er3d_merge (
    input  wire logic                                aclk,
    input  wire logic                                load,
    input  wire er3d_pkg::sum_t                      sum_x,
    input  wire er3d_pkg::sum_t                      sum_y,
    input  wire er3d_pkg::sum_t                      sum_z,
    output logic [er3d_pkg::OUT_DATA_W-1:0]          tdata
);
    import er3d_pkg::*;

    localparam int PAD_W = OUT_DATA_W - 3 * OUT_W;

    logic [OUT_DATA_W-1:0] tdata_reg;
    logic [OUT_W-1:0]      x_out;
    logic [OUT_W-1:0]      y_out;
    logic [OUT_W-1:0]      z_out;

    function automatic logic [OUT_W-1:0] clamp(input sum_t s);
        logic [OUT_W-1:0] r;
        if (s > sum_t'(OUT_MAX)) begin
            r = OUT_W'(OUT_MAX);
        end else if (s < sum_t'(OUT_MIN)) begin
            r = OUT_W'(OUT_MIN);
        end else begin
            r = s[OUT_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        x_out = clamp(sum_x);
        y_out = clamp(sum_y);
        z_out = clamp(sum_z);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= {{PAD_W{1'b0}}, z_out, y_out, x_out};
        end
    end

    assign tdata = tdata_reg;

endmodule

`default_nettype wire

// ===== src/euler_rotation_3d.sv =====
// Top level of the Z-Y-X Euler-angle vector rotator.
// Rotates each input vector by Rz*Ry*Rx. Three lanes, one per matrix row, take one
// vector per clock while s_tready is high; a result passes through the product
// register, rounded-sum register and output register, and each stage moves on as soon
// as the next one is free, so up to two further beats are taken while a result waits.
// Writing an angle register starts a matrix rebuild on one shared 32x32 multiplier:
// six polynomial sines of six multiplies each plus fourteen matrix products, during
// which s_tready stays low. A further angle write restarts the rebuild. After reset
// the matrix is the identity and no rebuild runs. Outputs are rounded half up and
// clamped to 17 bits signed.
`default_nettype none

module euler_rotation_3d (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [1:0]                          cfg_addr,
    input  wire logic [er3d_pkg::ANGLE_W-1:0]        cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [er3d_pkg::IN_DATA_W-1:0]      s_tdata,   // x_in, y_in, z_in
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [er3d_pkg::OUT_DATA_W-1:0]          m_tdata    // x_out, y_out, z_out, pad
);
    import er3d_pkg::*;

    logic      busy;
    coef_mat_t coef;
    lane_ctl_t ctl;
    sum_t      sums [NUM_LANES];
    sample_t   x_in;
    sample_t   y_in;
    sample_t   z_in;
    logic      v1_reg, v1_next;
    logic      v2_reg, v2_next;
    logic      mv_reg, mv_next;
    logic      out_ready;
    logic      s2_ready;
    logic      s1_ready;
    logic      accept;

    assign x_in = s_tdata[SAMPLE_W-1:0];
    assign y_in = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign z_in = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

    er3d_coef u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .busy      (busy),
        .coef      (coef)
    );

    always_comb begin
        out_ready     = !mv_reg || m_tready;
        s2_ready      = !v2_reg || out_ready;
        s1_ready      = !v1_reg || s2_ready;
        s_tready      = s1_ready && !busy;
        accept        = s_tvalid && s_tready;
        ctl.load_prod = accept;
        ctl.load_sum  = v1_reg && s2_ready;
        v1_next       = s1_ready ? accept : v1_reg;
        v2_next       = s2_ready ? v1_reg : v2_reg;
        mv_next       = out_ready ? v2_reg : mv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            mv_reg <= mv_next;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        er3d_lane u_lane (
            .aclk   (aclk),
            .ctl    (ctl),
            .coef_a (coef[3*g]),
            .coef_b (coef[3*g+1]),
            .coef_c (coef[3*g+2]),
            .x_in   (x_in),
            .y_in   (y_in),
            .z_in   (z_in),
            .sum    (sums[g])
        );
    end

    er3d_merge u_merge (
        .aclk  (aclk),
        .load  (v2_reg && out_ready),
        .sum_x (sums[0]),
        .sum_y (sums[1]),
        .sum_z (sums[2]),
        .tdata (m_tdata)
    );

    assign m_tvalid = mv_reg;

    a_no_beat_in_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready)
        else $error("input beat taken during matrix rebuild");

    a_angle_write_starts_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && (cfg_addr == REG_ANGLE_X || cfg_addr == REG_ANGLE_Y
            || cfg_addr == REG_ANGLE_Z)) |=> busy)
        else $error("angle write did not start a rebuild");

    a_result_from_sum_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> $past(v2_reg))
        else $error("result beat appeared without a sum behind it");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the ZYX Euler-angle rotator: angle setup, vector stream, scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import er3d_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int unsigned IDLE_PCT = 38;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASES = 12;
    localparam int unsigned PHASE_BEATS = 150;
    localparam int unsigned FRAC = 16;
    localparam longint unsigned SIN_A = 64'd1686629713;
    localparam longint unsigned SIN_B = 64'd693598668;
    localparam longint unsigned SIN_C = 64'd85569306;
    localparam longint unsigned SIN_D = 64'd5026995;
    localparam longint unsigned SIN_E = 64'd172272;
    localparam longint OUT_HI = 65535;
    localparam longint OUT_LO = -65536;

    typedef struct packed {
        logic signed [OUT_W-1:0] z;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] x;
    } rotated_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [ANGLE_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic [ANGLE_W-1:0] turns [3];
    longint rot_coef [9];
    rotated_t rotated_q [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit steady = 1'b0;

    euler_rotation_3d dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint sine_of_turn(input logic [ANGLE_W-1:0] a);
        logic [1:0] quad;
        longint unsigned u;
        longint unsigned xq;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned s;
        quad = a[15:14];
        u = quad[0] ? (64'd16384 - a[13:0]) : a[13:0];
        xq = u << 16;
        x2 = (xq * xq) >> 30;
        p = SIN_E;
        p = SIN_D - ((x2 * p) >> 30);
        p = SIN_C - ((x2 * p) >> 30);
        p = SIN_B - ((x2 * p) >> 30);
        p = SIN_A - ((x2 * p) >> 30);
        s = (xq * p) >> 30;
        s = (s + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
        if (s > (64'd1 << FRAC))
            s = 64'd1 << FRAC;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint scale_round(input longint a, input longint b);
        longint p;
        p = a * b + (longint'(1) << (FRAC - 1));
        return p >>> FRAC;
    endfunction

    function automatic void rebuild_matrix();
        longint sx, cx, sy, cy, sz, cz, czsy, szsy;
        sx = sine_of_turn(turns[0]);
        cx = sine_of_turn(turns[0] + QUARTER);
        sy = sine_of_turn(turns[1]);
        cy = sine_of_turn(turns[1] + QUARTER);
        sz = sine_of_turn(turns[2]);
        cz = sine_of_turn(turns[2] + QUARTER);
        czsy = scale_round(cz, sy);
        szsy = scale_round(sz, sy);
        rot_coef[0] = scale_round(cz, cy);
        rot_coef[1] = -scale_round(sz, cx) + scale_round(czsy, sx);
        rot_coef[2] = scale_round(sz, sx) + scale_round(czsy, cx);
        rot_coef[3] = scale_round(sz, cy);
        rot_coef[4] = scale_round(cz, cx) + scale_round(szsy, sx);
        rot_coef[5] = -scale_round(cz, sx) + scale_round(szsy, cx);
        rot_coef[6] = -sy;
        rot_coef[7] = scale_round(cy, sx);
        rot_coef[8] = scale_round(cy, cx);
    endfunction

    function automatic rotated_t rotate_vector(input sample_t vx, input sample_t vy,
                                               input sample_t vz);
        rotated_t r;
        longint acc;
        longint v [3];
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        for (int row = 0; row < 3; row++) begin
            acc = rot_coef[row*3] * v[0] + rot_coef[row*3+1] * v[1]
                + rot_coef[row*3+2] * v[2];
            acc = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
            if (acc > OUT_HI)
                acc = OUT_HI;
            if (acc < OUT_LO)
                acc = OUT_LO;
            case (row)
                0: r.x = acc[OUT_W-1:0];
                1: r.y = acc[OUT_W-1:0];
                default: r.z = acc[OUT_W-1:0];
            endcase
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        rotated_t want;
        rotated_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[OUT_W-1:0];
            got.y = m_tdata[2*OUT_W-1:OUT_W];
            got.z = m_tdata[3*OUT_W-1:2*OUT_W];
            if (rotated_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: x=%0d y=%0d z=%0d", got.x, got.y, got.z);
            end else begin
                want = rotated_q.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                                 want.x, want.y, want.z, got.x, got.y, got.z);
                end
            end
        end
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_vector(input sample_t vx, input sample_t vy, input sample_t vz);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {vz, vy, vx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        rotated_q.push_back(rotate_vector(vx, vy, vz));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (rotated_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [ANGLE_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx != REG_UNUSED) begin
            turns[idx] = val;
            rebuild_matrix();
        end
    endtask

    task automatic set_angles(input logic [ANGLE_W-1:0] ax, input logic [ANGLE_W-1:0] ay,
                              input logic [ANGLE_W-1:0] az, input bit stray,
                              input logic [ANGLE_W-1:0] stray_val);
        wait_drained();
        write_reg(REG_ANGLE_X, ax);
        write_reg(REG_ANGLE_Y, ay);
        write_reg(REG_ANGLE_Z, az);
        if (stray)
            write_reg(REG_UNUSED, stray_val);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_corners(input int unsigned count);
        sample_t lo, hi;
        lo = 16'sh8000;
        hi = 16'sh7FFF;
        for (int unsigned i = 0; i < count; i++)
            send_vector(i[0] ? hi : lo, i[1] ? hi : lo, i[2] ? hi : lo);
    endtask

    task automatic test_reset_identity();
        send_corners(8);
        send_vector(16'sd0, 16'sd0, 16'sd0);
        send_vector(16'sd1, -16'sd1, 16'sd0);
    endtask

    task automatic test_quadrant_angles();
        set_angles(16'h4000, 16'h8000, 16'hC000, 1'b0, '0);
        send_corners(3);
        set_angles(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0);
        send_corners(3);
        set_angles(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF);
        send_corners(3);
    endtask

    function automatic logic [ANGLE_W-1:0] pick_angle();
        logic [ANGLE_W-1:0] a;
        a = ANGLE_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 4) == 0)
            a = {a[15:14], 14'd0};
        return a;
    endfunction

    function automatic sample_t pick_sample(input int unsigned mode);
        sample_t v;
        case (mode)
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 16'sh8000;
                    1: v = 16'sh7FFF;
                    2: v = 16'sd0;
                    3: v = -16'sd1;
                    default: v = 16'sd1;
                endcase
            end
            1: v = sample_t'($urandom_range(0, 16)) - 16'sd8;
            default: v = sample_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic test_random_rotation();
        int unsigned mode;
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            set_angles(pick_angle(), pick_angle(), pick_angle(), $urandom_range(0, 2) == 0,
                       ANGLE_W'($urandom_range(0, 65535)));
            steady = (ph == 0);
            for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
                mode = $urandom_range(0, 99);
                mode = (mode < 15) ? 0 : (mode < 30) ? 1 : 2;
                send_vector(pick_sample(mode), pick_sample(mode), pick_sample(mode));
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        turns[0] = '0;
        turns[1] = '0;
        turns[2] = '0;
        rebuild_matrix();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_identity();
        test_quadrant_angles();
        test_random_rotation();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
